// ===== src/icy_md_pkg.sv =====
// ---------------------------------------------------------------------------
// icy_md_pkg: shared types and codes of the stream metadata demultiplexer
// Holds the result kind codes and the entry passed from the framing front
// end to the title matcher back end.
// ---------------------------------------------------------------------------
package icy_md_pkg;

    // Result kind codes.
    localparam logic [1:0] KIND_AUDIO   = 2'd0;
    localparam logic [1:0] KIND_LENGTH  = 2'd1;
    localparam logic [1:0] KIND_META    = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    localparam int COUNT_W = 24;
    localparam int META_W  = 12;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified beat on its way to the matcher.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       clear;      // clear the matcher before this beat
        logic       block_end;  // last byte of a nonempty block
    } icy_md_entry_t;

endpackage

// ===== src/icy_md_front.sv =====
// ---------------------------------------------------------------------------
// icy_md_front: framing front end
// Tracks the audio and metadata byte counters and tags each beat as audio,
// length byte, metadata byte or restart.
// ---------------------------------------------------------------------------
module icy_md_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [23:0]               meta_interval,
    input  logic                      in_valid,
    input  logic                      in_command,
    input  logic [7:0]                in_byte,
    input  logic                      queue_ready,
    output logic                      push,
    output icy_md_pkg::icy_md_entry_t push_entry
);
    import icy_md_pkg::*;

    logic               reading_meta_reg, reading_meta_next;
    logic               await_length_reg, await_length_next;
    logic [COUNT_W-1:0] data_left_reg, data_left_next;
    logic [META_W-1:0]  meta_left_reg, meta_left_next;

    logic               rm_tmp;
    logic               al_tmp;
    logic [COUNT_W-1:0] dl_tmp;
    logic [COUNT_W-1:0] dl_dec;
    logic [META_W-1:0]  ml_dec;

    assign push = in_valid && queue_ready;

    // Classify the beat and work out the next framing state.
    always_comb begin
        reading_meta_next = reading_meta_reg;
        await_length_next = await_length_reg;
        data_left_next    = data_left_reg;
        meta_left_next    = meta_left_reg;
        push_entry.out_byte  = in_byte;
        push_entry.kind      = KIND_AUDIO;
        push_entry.clear     = 1'b0;
        push_entry.block_end = 1'b0;
        rm_tmp = reading_meta_reg;
        al_tmp = await_length_reg;
        dl_tmp = data_left_reg;
        dl_dec = '0;
        ml_dec = meta_left_reg - META_W'(1);

        if (in_command) begin
            data_left_next    = meta_interval;
            reading_meta_next = 1'b0;
            await_length_next = 1'b0;
            meta_left_next    = '0;
            push_entry.out_byte = 8'd0;
            push_entry.kind     = KIND_RESTART;
            push_entry.clear    = 1'b1;
        end else if (meta_interval != '0) begin
            // An empty block counter inside a block closes it silently.
            if (rm_tmp && !al_tmp && meta_left_reg == '0) begin
                rm_tmp = 1'b0;
                dl_tmp = meta_interval;
            end
            // An exhausted audio counter makes this beat the length byte.
            if (!rm_tmp && dl_tmp == '0) begin
                rm_tmp = 1'b1;
                al_tmp = 1'b1;
            end
            reading_meta_next = rm_tmp;
            await_length_next = al_tmp;
            data_left_next    = dl_tmp;
            dl_dec = dl_tmp - COUNT_W'(1);

            if (!rm_tmp) begin
                push_entry.kind = KIND_AUDIO;
                data_left_next  = dl_dec;
                if (dl_dec == '0) begin
                    reading_meta_next = 1'b1;
                    await_length_next = 1'b1;
                end
            end else if (al_tmp) begin
                push_entry.kind   = KIND_LENGTH;
                await_length_next = 1'b0;
                if (in_byte == 8'd0) begin
                    reading_meta_next = 1'b0;
                    data_left_next    = meta_interval;
                end else begin
                    meta_left_next   = {in_byte, 4'b0000};
                    push_entry.clear = 1'b1;
                end
            end else begin
                push_entry.kind = KIND_META;
                meta_left_next  = ml_dec;
                if (ml_dec == '0) begin
                    push_entry.block_end = 1'b1;
                    reading_meta_next    = 1'b0;
                    data_left_next       = meta_interval;
                end
            end
        end
    end

    // Framing state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reading_meta_reg <= 1'b0;
            await_length_reg <= 1'b0;
            data_left_reg    <= '0;
            meta_left_reg    <= '0;
        end else if (push) begin
            reading_meta_reg <= reading_meta_next;
            await_length_reg <= await_length_next;
            data_left_reg    <= data_left_next;
            meta_left_reg    <= meta_left_next;
        end
    end

endmodule

// ===== src/icy_md_queue.sv =====
// ---------------------------------------------------------------------------
// icy_md_queue: short queue between front and back ends
// A small register queue that lets the framing and matching halves stall
// independently of each other.
// ---------------------------------------------------------------------------
module icy_md_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  icy_md_pkg::icy_md_entry_t push_entry,
    output logic                      not_full,
    input  logic                      pop,
    output logic                      not_empty,
    output icy_md_pkg::icy_md_entry_t pop_entry
);
    import icy_md_pkg::*;

    icy_md_entry_t       store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign not_full  = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_entry = store_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== src/icy_md_back.sv =====
// ---------------------------------------------------------------------------
// icy_md_back: title matcher back end
// Matches the title pattern without regard to case inside metadata blocks,
// tags title bytes and holds the result in the output register.
// ---------------------------------------------------------------------------
module icy_md_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      entry_valid,
    input  icy_md_pkg::icy_md_entry_t entry,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                out_byte,
    output logic [1:0]                out_kind,
    output logic                      out_title,
    output logic                      out_block_end,
    output logic                      out_title_found
);
    import icy_md_pkg::*;

    localparam logic [3:0] PATTERN_LEN = 4'd13;

    // Lower-case pattern character at a given match position.
    function automatic logic [7:0] pattern_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "s";
            4'd1:    c = "t";
            4'd2:    c = "r";
            4'd3:    c = "e";
            4'd4:    c = "a";
            4'd5:    c = "m";
            4'd6:    c = "t";
            4'd7:    c = "i";
            4'd8:    c = "t";
            4'd9:    c = "l";
            4'd10:   c = "e";
            4'd11:   c = "=";
            4'd12:   c = "'";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    logic [3:0] match_pos_reg, match_pos_next;
    logic       capturing_reg, capturing_next;
    logic       found_reg, found_next;
    logic       ended_reg, ended_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [1:0] kind_reg;
    logic       title_reg, title_next;
    logic       bend_reg;
    logic       tfound_reg;
    logic [7:0] lc;
    logic [3:0] pos_inc;

    assign pop = entry_valid && (!valid_reg || out_ready);
    assign lc  = (entry.out_byte >= "A" && entry.out_byte <= "Z") ?
                 entry.out_byte + 8'd32 : entry.out_byte;
    assign pos_inc = match_pos_reg + 4'd1;

    // Matcher step for one metadata byte.
    always_comb begin
        match_pos_next = match_pos_reg;
        capturing_next = capturing_reg;
        found_next     = found_reg;
        ended_next     = ended_reg;
        title_next     = 1'b0;
        if (entry.clear) begin
            match_pos_next = '0;
            capturing_next = 1'b0;
            found_next     = 1'b0;
            ended_next     = 1'b0;
        end else if (entry.kind == KIND_META && !ended_reg) begin
            if (entry.out_byte == 8'd0) begin
                ended_next     = 1'b1;
                capturing_next = 1'b0;
            end else if (capturing_reg) begin
                if (entry.out_byte == "'") begin
                    capturing_next = 1'b0;
                end else begin
                    title_next = 1'b1;
                end
            end else if (!found_reg) begin
                if (match_pos_reg < PATTERN_LEN && lc == pattern_char(match_pos_reg)) begin
                    match_pos_next = pos_inc;
                    if (pos_inc == PATTERN_LEN) begin
                        found_next     = 1'b1;
                        capturing_next = 1'b1;
                        match_pos_next = '0;
                    end
                end else begin
                    match_pos_next = (lc == pattern_char(4'd0)) ? 4'd1 : 4'd0;
                end
            end
        end
    end

    // Matcher state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_pos_reg <= '0;
            capturing_reg <= 1'b0;
            found_reg     <= 1'b0;
            ended_reg     <= 1'b0;
            valid_reg     <= 1'b0;
        end else begin
            if (pop) begin
                match_pos_reg <= match_pos_next;
                capturing_reg <= capturing_next;
                found_reg     <= found_next;
                ended_reg     <= ended_next;
                valid_reg     <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (pop) begin
            byte_reg   <= entry.out_byte;
            kind_reg   <= entry.kind;
            title_reg  <= title_next;
            bend_reg   <= entry.block_end;
            tfound_reg <= entry.block_end && found_next;
        end
    end

    assign out_valid       = valid_reg;
    assign out_byte        = byte_reg;
    assign out_kind        = kind_reg;
    assign out_title       = title_reg;
    assign out_block_end   = bend_reg;
    assign out_title_found = tfound_reg;

endmodule

// ===== src/icy_metadata_demux_title_extract.sv =====
// ---------------------------------------------------------------------------
// icy_metadata_demux_title_extract: stream metadata demultiplexer
// Tags every stream byte as audio, length, metadata or restart and marks the
// stream title found inside metadata blocks.
//
//   Channel  Direction  Payload
//   s_       in         tuser: command; tdata: data_byte
//   m_       out        tuser: kind; tdata: out_byte, is_title, block_end,
//                       title_found
//   cfg_     in         cfg_wr_data: meta_interval
//
// One beat is accepted per cycle while the queue is not full. A result is
// formed as its input beat passes through the four-entry queue and is then
// loaded into the output register.
// Reset clears all framing and matcher state and the interval register.
// A stalled output fills the queue; s_tready drops only when it is full.
// ---------------------------------------------------------------------------
module icy_metadata_demux_title_extract (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data,   // meta_interval
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic        s_tuser,       // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [7:0] out_byte, [8] is_title,
                                       // [9] block_end, [10] title_found
    output logic [1:0]  m_tuser        // [1:0] kind
);
    import icy_md_pkg::*;

    logic [23:0]   meta_interval_reg;
    logic          push;
    logic          queue_not_full;
    logic          queue_not_empty;
    logic          pop;
    icy_md_entry_t push_entry;
    icy_md_entry_t pop_entry;
    logic [7:0]    out_byte;
    logic          out_title;
    logic          out_block_end;
    logic          out_title_found;

    // Interval register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_interval_reg <= '0;
        end else if (cfg_wr_en) begin
            meta_interval_reg <= cfg_wr_data;
        end
    end

    assign s_tready = queue_not_full;

    icy_md_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .meta_interval (meta_interval_reg),
        .in_valid      (s_tvalid),
        .in_command    (s_tuser),
        .in_byte       (s_tdata),
        .queue_ready   (queue_not_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    icy_md_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .not_full   (queue_not_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .pop_entry  (pop_entry)
    );

    icy_md_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .entry_valid     (queue_not_empty),
        .entry           (pop_entry),
        .pop             (pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_byte        (out_byte),
        .out_kind        (m_tuser),
        .out_title       (out_title),
        .out_block_end   (out_block_end),
        .out_title_found (out_title_found)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {5'b00000, out_title_found, out_block_end, out_title, out_byte};

endmodule

// ===== verif/icy_metadata_demux_title_extract_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// icy_metadata_demux_title_extract_tb: self-checking bench for the demux
// Streams audio frames, length bytes and metadata blocks that carry stream
// title text, with random idle cycles on both channels. A cycle-free copy
// of the framing counters and the title matcher predicts every output beat.
// ---------------------------------------------------------------------------
module icy_metadata_demux_title_extract_tb;

    import icy_md_pkg::*;

    // Matched text and the quote that closes a title.
    localparam int                  KEY_LEN       = 13;
    localparam logic [8*KEY_LEN-1:0] TITLE_KEY    = "streamtitle='";
    localparam logic [7:0]          QUOTE_CHAR    = 8'h27;
    localparam logic [8*15-1:0]     DIRECTED_TEXT = "STREAMtitle='A'";
    localparam logic                CMD_BYTE      = 1'b0;
    localparam logic                CMD_RESTART   = 1'b1;
    localparam int                  RANDOM_BEATS  = 1750;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } stream_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       is_title;
        logic       block_end;
        logic       title_found;
    } byte_tag_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [23:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;   // [7:0] data_byte
    logic        s_tuser     = 1'b0; // [0] command
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;            // [7:0] out_byte, [8] is_title,
                                     // [9] block_end, [10] title_found
    logic [1:0]  m_tuser;            // [1:0] kind

    icy_metadata_demux_title_extract dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // Stimulus and scoreboard storage.
    stream_item_t pending_beats[$];
    stream_item_t frame_beats[$];
    logic [7:0]   meta_text[$];
    byte_tag_t    expected_tags[$];
    int           beats_queued   = 0;
    int           mismatch_count = 0;
    bit           beat_on_bus    = 1'b0;
    bit           src_steady     = 1'b0;
    bit           sink_steady    = 1'b0;
    int           gap_left       = 0;
    int           stall_left     = 0;

    // Predicted framing and matcher state.
    logic [23:0] interval_cfg  = '0;
    logic        in_meta       = 1'b0;
    logic        want_length   = 1'b0;
    logic [23:0] audio_left    = '0;
    logic [11:0] meta_left     = '0;
    logic [3:0]  match_len     = '0;
    logic        in_title      = 1'b0;
    logic        title_seen    = 1'b0;
    logic        text_done     = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] key_char(input int i);
        return TITLE_KEY[8*(KEY_LEN-1-i) +: 8];
    endfunction

    function automatic void clear_matcher();
        match_len  = '0;
        in_title   = 1'b0;
        title_seen = 1'b0;
        text_done  = 1'b0;
    endfunction

    // One matcher step on a metadata byte; returns 1 for a title byte.
    function automatic logic scan_title(input logic [7:0] b);
        logic [7:0] c;
        if (text_done)
            return 1'b0;
        if (b == 8'h00) begin
            text_done = 1'b1;
            in_title  = 1'b0;
            return 1'b0;
        end
        if (in_title) begin
            if (b == QUOTE_CHAR) begin
                in_title = 1'b0;
                return 1'b0;
            end
            return 1'b1;
        end
        if (title_seen)
            return 1'b0;
        c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (match_len < KEY_LEN && c == key_char(match_len)) begin
            match_len = match_len + 4'd1;
            if (match_len == KEY_LEN) begin
                title_seen = 1'b1;
                in_title   = 1'b1;
                match_len  = '0;
            end
        end else begin
            match_len = (c == key_char(0)) ? 4'd1 : 4'd0;
        end
        return 1'b0;
    endfunction

    // Tags one accepted input beat and advances the predicted state.
    function automatic byte_tag_t predict_tag(input logic cmd, input logic [7:0] b);
        byte_tag_t r;
        r          = '0;
        r.out_byte = b;
        r.kind     = KIND_AUDIO;
        if (cmd == CMD_RESTART) begin
            audio_left  = interval_cfg;
            in_meta     = 1'b0;
            want_length = 1'b0;
            meta_left   = '0;
            clear_matcher();
            r.out_byte = 8'h00;
            r.kind     = KIND_RESTART;
        end else if (interval_cfg != 0) begin
            // A finished block hands back to audio.
            if (in_meta && !want_length && meta_left == 0) begin
                in_meta    = 1'b0;
                audio_left = interval_cfg;
            end
            // An exhausted audio counter means this is the length byte.
            if (!in_meta && audio_left == 0) begin
                in_meta     = 1'b1;
                want_length = 1'b1;
            end
            if (!in_meta) begin
                audio_left = audio_left - 24'd1;
                if (audio_left == 0) begin
                    in_meta     = 1'b1;
                    want_length = 1'b1;
                end
            end else if (want_length) begin
                r.kind      = KIND_LENGTH;
                want_length = 1'b0;
                if (b == 8'h00) begin
                    in_meta    = 1'b0;
                    audio_left = interval_cfg;
                end else begin
                    meta_left = {b, 4'h0};
                    clear_matcher();
                end
            end else begin
                r.kind     = KIND_META;
                r.is_title = scan_title(b);
                meta_left  = meta_left - 12'd1;
                if (meta_left == 0) begin
                    r.block_end   = 1'b1;
                    r.title_found = title_seen;
                    in_meta       = 1'b0;
                    audio_left    = interval_cfg;
                end
            end
        end
        return r;
    endfunction

    // Source side: presents queued beats and predicts each one accepted.
    always @(posedge aclk) begin : source_side
        stream_item_t beat;
        if (!aresetn) begin
            beat_on_bus = 1'b0;
            s_tvalid   <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_tags.push_back(predict_tag(s_tuser, s_tdata));
                beat_on_bus = 1'b0;
            end
            if (!beat_on_bus) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_beats.size() != 0) begin
                    beat        = pending_beats.pop_front();
                    s_tuser    <= beat.cmd;
                    s_tdata    <= beat.data;
                    beat_on_bus = 1'b1;
                    gap_left    = src_steady ? 0 : $urandom_range(0, 5);
                end
            end
            s_tvalid <= beat_on_bus;
        end
    end

    task automatic flag_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Sink side: checks each result beat against the oldest prediction.
    always @(posedge aclk) begin : sink_side
        byte_tag_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tags.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0h",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = expected_tags.pop_front();
                flag_field("out_byte", want.out_byte, m_tdata[7:0]);
                flag_field("kind", want.kind, m_tuser);
                flag_field("is_title", want.is_title, m_tdata[8]);
                flag_field("block_end", want.block_end, m_tdata[9]);
                flag_field("title_found", want.title_found, m_tdata[10]);
            end
            stall_left = sink_steady ? 0 : $urandom_range(0, 5);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_beat(input logic cmd, input logic [7:0] data);
        pending_beats.push_back(stream_item_t'{cmd: cmd, data: data});
        beats_queued++;
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || beat_on_bus || expected_tags.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_interval(input logic [23:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        interval_cfg = value;
    endtask

    // Printable text byte that never closes a title; sometimes a high byte.
    function automatic logic [7:0] title_char();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(128, 255));
        c = 8'($urandom_range(32, 126));
        return (c == QUOTE_CHAR) ? "_" : c;
    endfunction

    task automatic add_key(input int upto);
        logic [7:0] c;
        for (int i = 0; i < upto; i++) begin
            c = key_char(i);
            if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
                c = c - 8'd32;
            meta_text.push_back(c);
        end
    endtask

    task automatic add_text(input int n);
        for (int i = 0; i < n; i++)
            meta_text.push_back(title_char());
    endtask

    // Fills a metadata block of nbytes with title text of a random shape.
    task automatic build_meta(input int nbytes);
        logic [7:0] pad;
        meta_text.delete();
        case ($urandom_range(0, 6))
            0: begin
                // Plain title between other text.
                add_text($urandom_range(0, 10));
                add_key(KEY_LEN);
                add_text($urandom_range(0, 8));
                meta_text.push_back(QUOTE_CHAR);
                add_text($urandom_range(0, 4));
            end
            1: begin
                // Title without a closing quote.
                add_text($urandom_range(0, 5));
                add_key(KEY_LEN);
                add_text(nbytes);
            end
            2: begin
                // Broken pattern, then the full one.
                add_key($urandom_range(1, KEY_LEN - 1));
                add_text($urandom_range(0, 3));
                add_key(KEY_LEN);
                add_text($urandom_range(0, 6));
                meta_text.push_back(QUOTE_CHAR);
            end
            3: begin
                // Two patterns; only the first title counts.
                add_key(KEY_LEN);
                add_text($urandom_range(0, 4));
                meta_text.push_back(QUOTE_CHAR);
                add_key(KEY_LEN);
                add_text($urandom_range(1, 4));
                meta_text.push_back(QUOTE_CHAR);
            end
            4: begin
                // A zero byte ends the text before the pattern.
                add_text($urandom_range(0, 3));
                meta_text.push_back(8'h00);
                add_key(KEY_LEN);
                add_text($urandom_range(1, 4));
            end
            5: begin
                for (int i = 0; i < nbytes; i++)
                    meta_text.push_back(8'($urandom));
            end
            default: begin
                // Repeated first letter restarts the match.
                meta_text.push_back("S");
                meta_text.push_back("s");
                add_key(KEY_LEN);
                add_text($urandom_range(0, 6));
                meta_text.push_back(QUOTE_CHAR);
            end
        endcase
        pad = ($urandom_range(0, 2) == 0) ? title_char() : 8'h00;
        for (int i = 0; i < nbytes; i++)
            frame_beats.push_back(stream_item_t'{cmd: CMD_BYTE,
                data: (i < meta_text.size()) ? meta_text[i] : pad});
    endtask

    // One audio frame plus its metadata; cut short now and then.
    task automatic run_frame(output bit cut);
        int len;
        int keep;
        bit huge;
        frame_beats.delete();
        for (int i = 0; i < interval_cfg; i++)
            frame_beats.push_back(stream_item_t'{cmd: CMD_BYTE, data: 8'($urandom)});
        huge = ($urandom_range(0, 19) == 0);
        if (huge)
            len = $urandom_range(128, 255);
        else if ($urandom_range(0, 5) == 0)
            len = 0;
        else
            len = $urandom_range(1, 3);
        frame_beats.push_back(stream_item_t'{cmd: CMD_BYTE, data: 8'(len)});
        build_meta(huge ? 40 : 16 * len);
        cut  = huge || $urandom_range(0, 11) == 0;
        keep = cut ? $urandom_range(1, frame_beats.size()) : frame_beats.size();
        for (int i = 0; i < keep; i++)
            push_beat(frame_beats[i].cmd, frame_beats[i].data);
    endtask

    task automatic run_episode();
        bit cut;
        push_beat(CMD_RESTART, 8'($urandom));
        for (int f = $urandom_range(1, 4); f > 0; f--) begin
            run_frame(cut);
            if (cut)
                break;
        end
        // Occasional stray beats before the next restart.
        if ($urandom_range(0, 9) == 0)
            for (int i = $urandom_range(1, 6); i > 0; i--)
                push_beat($urandom_range(0, 3) == 0, 8'($urandom));
    endtask

    initial begin
        int         phase;
        logic [23:0] value;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Interval zero: every data byte is audio.
        push_beat(CMD_BYTE, 8'hFF);
        push_beat(CMD_BYTE, 8'h00);
        push_beat(CMD_RESTART, 8'hA5);
        wait_drained();
        // New interval without a restart: the first byte is a length byte.
        write_interval(24'd2);
        push_beat(CMD_BYTE, 8'h01);
        for (int i = 0; i < 15; i++)
            push_beat(CMD_BYTE, DIRECTED_TEXT[8*(14-i) +: 8]);
        push_beat(CMD_BYTE, 8'h00);
        push_beat(CMD_BYTE, 8'h5A);
        push_beat(CMD_BYTE, 8'hC3);
        // Zero length byte: no block follows.
        push_beat(CMD_BYTE, 8'h00);
        push_beat(CMD_BYTE, 8'h11);
        push_beat(CMD_BYTE, 8'hEE);
        push_beat(CMD_RESTART, 8'h00);
        wait_drained();

        // Random phases, each with its own interval and idling mix.
        phase = 0;
        while (beats_queued < RANDOM_BEATS + 25) begin
            case (phase % 8)
                0:       value = 24'hFFFFFF;
                1:       value = 24'd1;
                2:       value = 24'd0;
                3:       value = 24'd16;
                4:       value = 24'd2;
                5:       value = 24'd37;
                6:       value = 24'($urandom_range(3, 24));
                default: value = 24'($urandom_range(1, 8));
            endcase
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            write_interval(value);
            if (value == 0 || value > 64) begin
                for (int i = 0; i < 40; i++)
                    push_beat($urandom_range(0, 7) == 0, 8'($urandom));
            end else begin
                for (int e = $urandom_range(3, 6); e > 0; e--)
                    run_episode();
            end
            wait_drained();
            phase++;
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Run limit.
    initial begin
        #(5_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
